FILE: rtl/core/tpm_pkg.sv
// ---------------------------------------------------------------------------
// tpm_pkg: shared types and constants for the tolerance pair matcher
// Sizes of the sorting chains, command and entry types, action codes and the
// control state machine encoding.
// ---------------------------------------------------------------------------
`default_nettype none

package tpm_pkg;

   // list storage
   localparam int DEPTH      = 128;
   localparam int VALUE_BITS = 16;

   // port field widths
   localparam int IN_VALUE_BITS = 16;
   localparam int TOL_BITS      = 16;
   localparam int MATCH_BITS    = 8;
   localparam int ACTION_BITS   = 2;

   // width used when comparing a difference against the tolerance
   localparam int CMP_BITS = (VALUE_BITS > TOL_BITS) ? VALUE_BITS : TOL_BITS;

   localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(1);

   // input word action codes; code 3 is ignored
   typedef enum logic [ACTION_BITS-1:0] {
      ACT_FIRST  = 2'd0,
      ACT_SECOND = 2'd1,
      ACT_FINISH = 2'd2
   } action_type;

   // per-cell operation, broadcast along a chain
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type            op;
      logic [VALUE_BITS-1:0]  value;
   } cell_cmd_type;

   typedef struct packed {
      logic                   valid;
      logic [VALUE_BITS-1:0]  data;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_REPORT
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/tolerance_pair_matcher_top.sv
// ---------------------------------------------------------------------------
// tolerance_pair_matcher_top: greedy tolerance matching of two sorted lists
// Loads fill two sorted cell chains; finish walks both heads and counts pairs.
//
//   channel  ports                                   handshake
//   req      req_action, req_value                   start / busy
//   rsp      rsp_match_count, rsp_overflowed         rsp_strobe, no stall
//   csr      csr_wr_data                             csr_wr_en
//
// A new load word is taken every cycle while the block is not busy.
// During a finish word the walk pops at least one chain head per cycle until
// either chain is empty, then the result is shown for one cycle and both
// chains are cleared.
// busy is high for the whole finish. Reset empties both lists and loads a
// tolerance of 1. Results cannot be held off by the receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module tolerance_pair_matcher_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire  [tpm_pkg::ACTION_BITS-1:0]     req_action,
   input  wire  [tpm_pkg::IN_VALUE_BITS-1:0]   req_value,
   output logic                                rsp_strobe,
   output logic [tpm_pkg::MATCH_BITS-1:0]      rsp_match_count,
   output logic                                rsp_overflowed,
   input  wire                                 csr_wr_en,
   input  wire  [tpm_pkg::TOL_BITS-1:0]        csr_wr_data
);

   tpm_pkg::state_type             state_ff, state_in;
   logic [tpm_pkg::TOL_BITS-1:0]   tol_ff;
   logic [tpm_pkg::MATCH_BITS-1:0] count_ff, count_in;
   logic                           ovf_ff, ovf_in;
   tpm_pkg::cell_cmd_type          cmd_a, cmd_b;
   tpm_pkg::entry_type             head_a, head_b;
   logic                           full_a, full_b;
   logic                           accept, both_valid;
   logic [tpm_pkg::CMP_BITS-1:0]   diff_ab, diff_ba, tol_ext;
   logic                           b_too_low, b_too_high;

   assign busy       = (state_ff != tpm_pkg::ST_IDLE);
   assign accept     = start && !busy;
   assign both_valid = head_a.valid && head_b.valid;

   // head comparison against the tolerance
   assign diff_ab    = tpm_pkg::CMP_BITS'(head_a.data - head_b.data);
   assign diff_ba    = tpm_pkg::CMP_BITS'(head_b.data - head_a.data);
   assign tol_ext    = tpm_pkg::CMP_BITS'(tol_ff);
   assign b_too_low  = (head_a.data > head_b.data) && (diff_ab > tol_ext);
   assign b_too_high = (head_b.data > head_a.data) && (diff_ba > tol_ext);

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= tpm_pkg::TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tpm_pkg::ST_IDLE: begin
            if (accept && (req_action == tpm_pkg::ACT_FINISH)) begin
               state_in = tpm_pkg::ST_WALK;
            end
         end
         tpm_pkg::ST_WALK: begin
            if (!both_valid) begin
               state_in = tpm_pkg::ST_REPORT;
            end
         end
         tpm_pkg::ST_REPORT: begin
            state_in = tpm_pkg::ST_IDLE;
         end
         default: begin
            state_in = tpm_pkg::ST_IDLE;
         end
      endcase
   end

   // chain commands, pair counter and overflow flag
   always_comb begin
      cmd_a    = '{op: tpm_pkg::CELL_HOLD,
                   value: tpm_pkg::VALUE_BITS'(req_value)};
      cmd_b    = cmd_a;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         tpm_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  tpm_pkg::ACT_FIRST: begin
                     if (full_a) ovf_in = 1'b1;
                     else        cmd_a.op = tpm_pkg::CELL_INSERT;
                  end
                  tpm_pkg::ACT_SECOND: begin
                     if (full_b) ovf_in = 1'b1;
                     else        cmd_b.op = tpm_pkg::CELL_INSERT;
                  end
                  tpm_pkg::ACT_FINISH: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tpm_pkg::ST_WALK: begin
            if (both_valid) begin
               if (b_too_low) begin
                  cmd_b.op = tpm_pkg::CELL_POP;
               end else if (b_too_high) begin
                  cmd_a.op = tpm_pkg::CELL_POP;
               end else begin
                  cmd_a.op = tpm_pkg::CELL_POP;
                  cmd_b.op = tpm_pkg::CELL_POP;
                  count_in = count_ff + tpm_pkg::MATCH_BITS'(1);
               end
            end
         end
         tpm_pkg::ST_REPORT: begin
            cmd_a.op = tpm_pkg::CELL_CLEAR;
            cmd_b.op = tpm_pkg::CELL_CLEAR;
            ovf_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpm_pkg::ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // sorted lists
   tpm_chain u_chain_a (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_a),
      .head  (head_a),
      .full  (full_a)
   );

   tpm_chain u_chain_b (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_b),
      .head  (head_b),
      .full  (full_b)
   );

   // result word
   assign rsp_strobe      = (state_ff == tpm_pkg::ST_REPORT);
   assign rsp_match_count = count_ff;
   assign rsp_overflowed  = ovf_ff;

   // report only once a list is exhausted
   a_report_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (busy && !both_valid))
      else $error("report with both lists pending");

   // counter starts from zero when a walk begins
   a_walk_count: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == tpm_pkg::ST_WALK) |-> (count_ff == '0))
      else $error("pair count not cleared at walk start");

   // after the report both lists are empty and the block is free
   a_report_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!busy && !head_a.valid && !head_b.valid && !ovf_ff))
      else $error("lists not cleared after report");

endmodule

`default_nettype wire

FILE: rtl/core/tpm_cell.sv
// ---------------------------------------------------------------------------
// tpm_cell: one slot of a sorted chain
// Holds one entry. On insert it keeps its value, takes the new value or takes
// its left neighbor's value so the chain stays ascending; on pop it takes its
// right neighbor's value; on clear it becomes empty.
// ---------------------------------------------------------------------------
`default_nettype none

module tpm_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  tpm_pkg::cell_cmd_type cmd,
   input  tpm_pkg::entry_type   left_ent,
   input  wire                  left_gt,
   input  tpm_pkg::entry_type   right_ent,
   output tpm_pkg::entry_type   ent,
   output logic                 gt
);

   logic                           valid_ff, valid_in;
   logic [tpm_pkg::VALUE_BITS-1:0] data_ff, data_in;
   logic                           take;

   // this entry is larger than the value being inserted
   assign gt  = valid_ff && (data_ff > cmd.value);
   assign ent = '{valid: valid_ff, data: data_ff};

   // slot changes on insert when it holds a larger value or is the first free one
   assign take = gt || (!valid_ff && left_ent.valid);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      unique case (cmd.op)
         tpm_pkg::CELL_INSERT: begin
            if (take) begin
               valid_in = 1'b1;
               data_in  = left_gt ? left_ent.data : cmd.value;
            end
         end
         tpm_pkg::CELL_POP: begin
            valid_in = right_ent.valid;
            data_in  = right_ent.data;
         end
         tpm_pkg::CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/tpm_chain.sv
// ---------------------------------------------------------------------------
// tpm_chain: sorted list as a row of cells
// Insert places a value in its sorted slot; pop drops the smallest entry and
// moves every entry one cell toward the head; clear empties every cell.
// ---------------------------------------------------------------------------
`default_nettype none

module tpm_chain (
   input  wire                   clock,
   input  wire                   reset,
   input  tpm_pkg::cell_cmd_type cmd,
   output tpm_pkg::entry_type    head,
   output logic                  full
);

   tpm_pkg::entry_type ent      [tpm_pkg::DEPTH];
   tpm_pkg::entry_type left_ent [tpm_pkg::DEPTH];
   tpm_pkg::entry_type right_ent[tpm_pkg::DEPTH];
   logic               gt       [tpm_pkg::DEPTH];
   logic               left_gt  [tpm_pkg::DEPTH];

   // neighbor wiring; the head sees an always-valid, never-greater left side
   for (genvar i = 0; i < tpm_pkg::DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_ent[i] = '{valid: 1'b1, data: '0};
         assign left_gt[i]  = 1'b0;
      end else begin : g_body
         assign left_ent[i] = ent[i-1];
         assign left_gt[i]  = gt[i-1];
      end
      if (i == tpm_pkg::DEPTH - 1) begin : g_tail
         assign right_ent[i] = '{valid: 1'b0, data: '0};
      end else begin : g_inner
         assign right_ent[i] = ent[i+1];
      end

      tpm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .left_ent  (left_ent[i]),
         .left_gt   (left_gt[i]),
         .right_ent (right_ent[i]),
         .ent       (ent[i]),
         .gt        (gt[i])
      );
   end

   assign head = ent[0];
   assign full = ent[tpm_pkg::DEPTH-1].valid;

   // the head is valid and no larger than the second entry whenever that one is valid
   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      ent[1].valid |-> (ent[0].valid && (ent[0].data <= ent[1].data)))
      else $error("chain head out of order");

   // a full chain never gets an insert
   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      full |-> (cmd.op != tpm_pkg::CELL_INSERT))
      else $error("insert into full chain");

endmodule

`default_nettype wire
